// ===== rtl/fla_pkg.sv =====
// ----------------------------------------------------------------------------
// fla_pkg: shared types and constants of the free-list allocator
// Segment record, cell control word, channel payloads and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package fla_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_BITS   = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Blocks must end at or below this address (top address never used).
  localparam logic [33:0] SPACE_END = (ADDR_BITS >= 32) ? 34'h0_FFFF_FFFF :
                                      ((34'd1 << ADDR_BITS) - 34'd1);

  localparam logic [2:0] ST_REUSED    = 3'd0;
  localparam logic [2:0] ST_GROWN     = 3'd1;
  localparam logic [2:0] ST_FREED     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_IGNORED   = 3'd4;
  localparam logic [2:0] ST_EXHAUSTED = 3'd5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] REG_FIT_MODE  = 2'd0;
  localparam logic [1:0] REG_HEADER    = 2'd1;
  localparam logic [1:0] REG_HEAP_BASE = 2'd2;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
  } fla_seg_t;

  // Control word broadcast to every cell of the table.
  typedef struct packed {
    logic             rot;   // whole row shifts one place toward cell 0
    logic             rm;    // cells at or above idx take the right neighbor
    logic             ins;   // cells above idx take the left neighbor, idx takes data
    logic             wr;    // cell widx takes data
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] widx;
    fla_seg_t         data;
  } fla_edit_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] request_bytes;
    logic [31:0] payload_address;
    logic [31:0] block_bytes;
  } fla_in_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [31:0] granted_bytes;
    logic [2:0]  status;
    logic [31:0] segment_bytes;
    logic [31:0] free_bytes;
  } fla_out_t;

endpackage

`default_nettype wire

// ===== rtl/fla_cell.sv =====
// ----------------------------------------------------------------------------
// fla_cell: one entry of the free-segment table
// Holds a segment and loads from a neighbor or from the broadcast data.
// ----------------------------------------------------------------------------
`default_nettype none

module fla_cell (
  input  wire logic                     clk,
  input  wire logic [fla_pkg::CNT_W-1:0] my_idx,
  input  wire fla_pkg::fla_edit_t        ctl,
  input  wire fla_pkg::fla_seg_t         from_left,
  input  wire fla_pkg::fla_seg_t         from_right,
  output fla_pkg::fla_seg_t              seg
);
  import fla_pkg::*;

  fla_seg_t seg_r;
  fla_seg_t seg_nxt;

  always_comb begin
    seg_nxt = seg_r;
    if (ctl.rot) begin
      seg_nxt = from_right;
    end else if (ctl.rm && (my_idx >= ctl.idx)) begin
      seg_nxt = from_right;
    end else if (ctl.ins && (my_idx > ctl.idx)) begin
      seg_nxt = from_left;
    end else if ((ctl.ins && (my_idx == ctl.idx)) || (ctl.wr && (my_idx == ctl.widx))) begin
      seg_nxt = ctl.data;
    end
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
  end

  assign seg = seg_r;

endmodule

`default_nettype wire

// ===== rtl/free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// free_list_allocator: address-ordered free-segment heap manager
// Allocates by first or best fit, grows the heap break, frees with coalescing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries allocate or free items;
//   out_valid/out_stall/out_data returns exactly one result per item.
//   Configuration goes through the APB-style cfg_ port (fit_mode at 0x0,
//   header_bytes at 0x4, heap_base at 0x8) while the block is idle.
//   The free table is a row of TABLE_DEPTH cells. Each item rotates the row
//   once around (one entry examined at cell 0 per cycle), then decides and
//   edits the row in place in the edit state, which also loads the result;
//   a new item is taken only once that edit is done and the block is idle.
//   The result sits in an output register; while the receiver stalls it, the
//   next item may be taken and scanned, but its edit waits for the register.
//   Reset (synchronous, rst_n low) empties the table, zeroes the break and
//   free total and restores the register defaults; table contents are not
//   cleared, only the entry count.
// ----------------------------------------------------------------------------
`default_nettype none

module free_list_allocator (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire fla_pkg::fla_in_t in_data,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output fla_pkg::fla_out_t     out_data,
  input  wire logic             cfg_psel,
  input  wire logic             cfg_penable,
  input  wire logic             cfg_pwrite,
  input  wire logic [3:0]       cfg_paddr,
  input  wire logic [31:0]      cfg_pwdata,
  output      logic [31:0]      cfg_prdata,
  output      logic             cfg_pready
);
  import fla_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EDIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic        fit_r;
  logic [6:0]  hdr_r;
  logic [31:0] base_r;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      brk_r, brk_nxt;
  logic [31:0]      free_r, free_nxt;

  fla_in_t          item_r;
  logic [IDX_W-1:0] j_r;

  logic             pick_v_r, exact_r;
  fla_seg_t         pick_r;
  logic [CNT_W-1:0] pick_idx_r;
  logic             left_v_r, right_v_r;
  fla_seg_t         left_r, right_r;
  logic [CNT_W-1:0] pos_r;

  logic     out_valid_r;
  fla_out_t out_r;

  fla_edit_t edit;
  fla_seg_t  cell_q [TABLE_DEPTH];
  fla_seg_t  head;

  // ---------------- configuration port ----------------
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_r  <= 1'b0;
      hdr_r  <= 7'd32;
      base_r <= 32'd0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_FIT_MODE:  fit_r  <= cfg_pwdata[0];
        REG_HEADER:    hdr_r  <= cfg_pwdata[6:0];
        REG_HEAP_BASE: base_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_FIT_MODE:  cfg_prdata = {31'd0, fit_r};
      REG_HEADER:    cfg_prdata = {25'd0, hdr_r};
      REG_HEAP_BASE: cfg_prdata = base_r;
      default:       cfg_prdata = 32'd0;
    endcase
  end

  // ---------------- cell row ----------------
  assign head = cell_q[0];

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    fla_seg_t left_in, right_in;
    if (k == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid
      assign left_in = cell_q[k-1];
    end
    if (k == TABLE_DEPTH - 1) begin : g_last
      assign right_in = cell_q[0];
    end else begin : g_inner
      assign right_in = cell_q[k+1];
    end
    fla_cell u_cell (
      .clk        (clk),
      .my_idx     (CNT_W'(k)),
      .ctl        (edit),
      .from_left  (left_in),
      .from_right (right_in),
      .seg        (cell_q[k])
    );
  end

  // ---------------- scan ----------------
  logic        in_xfer, scan_last, head_live, go;
  logic [32:0] need;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign scan_last = (j_r == IDX_W'(TABLE_DEPTH - 1));
  assign head_live = (CNT_W'(j_r) < cnt_r);
  assign need      = {1'b0, item_r.request_bytes} + {26'd0, hdr_r};
  assign go        = !out_valid_r || !out_stall;

  logic [31:0] fr_start;
  assign fr_start = item_r.payload_address - {25'd0, hdr_r};

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r    <= in_data;
      j_r       <= '0;
      pick_v_r  <= 1'b0;
      exact_r   <= 1'b0;
      left_v_r  <= 1'b0;
      right_v_r <= 1'b0;
      pos_r     <= '0;
    end else if (state_r == S_SCAN) begin
      j_r <= j_r + IDX_W'(1);
      if (head_live) begin
        if (item_r.opcode == OP_ALLOC) begin
          if (!fit_r) begin
            if (!pick_v_r && ({1'b0, head.len} >= need)) begin
              pick_v_r   <= 1'b1;
              pick_r     <= head;
              pick_idx_r <= CNT_W'(j_r);
            end
          end else if (!exact_r) begin
            if ({1'b0, head.len} == need) begin
              exact_r    <= 1'b1;
              pick_v_r   <= 1'b1;
              pick_r     <= head;
              pick_idx_r <= CNT_W'(j_r);
            end else if (({1'b0, head.len} > need) &&
                         (!pick_v_r || (head.len < pick_r.len))) begin
              pick_v_r   <= 1'b1;
              pick_r     <= head;
              pick_idx_r <= CNT_W'(j_r);
            end
          end
        end else begin
          if (head.start <= fr_start) begin
            left_v_r <= 1'b1;
            left_r   <= head;
            pos_r    <= CNT_W'(j_r) + CNT_W'(1);
          end else if (!right_v_r) begin
            right_v_r <= 1'b1;
            right_r   <= head;
          end
        end
      end
    end
  end

  // ---------------- decide and edit ----------------
  logic [31:0] gap;
  logic        whole;
  logic [32:0] grow_start;
  logic        exhausted;
  logic [32:0] fr_end, left_end;
  logic        bad, ovl, adj_l, adj_r;
  fla_out_t    res;

  assign gap        = pick_r.len - need[31:0];
  assign whole      = (gap <= {25'd0, hdr_r});
  assign grow_start = {1'b0, base_r} + {1'b0, brk_r};
  assign exhausted  = (({1'b0, grow_start} + {1'b0, need}) > SPACE_END) ||
                      (({1'b0, brk_r} + need) > 33'h0_FFFF_FFFF);
  assign fr_end     = {1'b0, fr_start} + {1'b0, item_r.block_bytes};
  assign left_end   = {1'b0, left_r.start} + {1'b0, left_r.len};
  assign bad        = (item_r.block_bytes == 32'd0) ||
                      (item_r.payload_address < {25'd0, hdr_r}) ||
                      ({1'b0, fr_end} > SPACE_END);
  assign ovl        = (left_v_r && (left_end > {1'b0, fr_start})) ||
                      (right_v_r && (fr_end > {1'b0, right_r.start}));
  assign adj_l      = left_v_r && (left_end == {1'b0, fr_start});
  assign adj_r      = right_v_r && (fr_end == {1'b0, right_r.start});

  always_comb begin
    edit     = '0;
    edit.rot = (state_r == S_SCAN);
    cnt_nxt  = cnt_r;
    brk_nxt  = brk_r;
    free_nxt = free_r;
    res      = '0;
    if (state_r == S_EDIT && go) begin
      if (item_r.opcode == OP_ALLOC) begin
        if (pick_v_r) begin
          res.status         = ST_REUSED;
          res.result_address = pick_r.start + {25'd0, hdr_r};
          if (whole) begin
            res.granted_bytes = pick_r.len;
            edit.rm           = 1'b1;
            edit.idx          = pick_idx_r;
            cnt_nxt           = cnt_r - CNT_W'(1);
          end else begin
            res.granted_bytes = need[31:0];
            edit.wr           = 1'b1;
            edit.widx         = pick_idx_r;
            edit.data.start   = pick_r.start + need[31:0];
            edit.data.len     = gap;
          end
          free_nxt = free_r - res.granted_bytes;
        end else if (exhausted) begin
          res.status = ST_EXHAUSTED;
        end else begin
          res.status         = ST_GROWN;
          res.granted_bytes  = need[31:0];
          res.result_address = grow_start[31:0] + {25'd0, hdr_r};
          brk_nxt            = brk_r + need[31:0];
        end
      end else begin
        if (bad || ovl) begin
          res.status = ST_IGNORED;
        end else if (!adj_l && !adj_r && (cnt_r >= CNT_W'(TABLE_DEPTH))) begin
          res.status = ST_FULL;
        end else begin
          res.status = ST_FREED;
          free_nxt   = free_r + item_r.block_bytes;
          if (adj_l && adj_r) begin
            edit.wr         = 1'b1;
            edit.widx       = pos_r - CNT_W'(1);
            edit.data.start = left_r.start;
            edit.data.len   = left_r.len + item_r.block_bytes + right_r.len;
            edit.rm         = 1'b1;
            edit.idx        = pos_r;
            cnt_nxt         = cnt_r - CNT_W'(1);
          end else if (adj_l) begin
            edit.wr         = 1'b1;
            edit.widx       = pos_r - CNT_W'(1);
            edit.data.start = left_r.start;
            edit.data.len   = left_r.len + item_r.block_bytes;
          end else if (adj_r) begin
            edit.wr         = 1'b1;
            edit.widx       = pos_r;
            edit.data.start = fr_start;
            edit.data.len   = right_r.len + item_r.block_bytes;
          end else begin
            edit.ins        = 1'b1;
            edit.idx        = pos_r;
            edit.data.start = fr_start;
            edit.data.len   = item_r.block_bytes;
            cnt_nxt         = cnt_r + CNT_W'(1);
          end
        end
      end
      res.segment_bytes = brk_nxt;
      res.free_bytes    = free_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_SCAN;
      S_SCAN: if (scan_last) state_nxt = S_EDIT;
      S_EDIT: if (go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      brk_r       <= 32'd0;
      free_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      brk_r   <= brk_nxt;
      free_r  <= free_nxt;
      if (state_r == S_EDIT && go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EDIT && go) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------- checks ----------------
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("segment count above table depth");

  a_scan_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_SCAN))
    else $error("transfer in did not start a scan");

  a_free_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_EDIT) |=> $stable(free_r) && $stable(brk_r))
    else $error("heap totals changed outside the edit cycle");

  a_edit_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EDIT && out_valid_r && out_stall) |=> (state_r == S_EDIT))
    else $error("edit committed while result register was occupied");

endmodule

`default_nettype wire

// ===== tb/fla_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fla_checker: heap bookkeeping mirror for the free-list allocator
// Follows config writes and input transfers, keeps its own free-segment table,
// break and free total, and compares every result transfer in order.
// ----------------------------------------------------------------------------
module fla_checker
  import fla_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  fla_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  fla_out_t    out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          errors,
  output int          pending
);

  logic [63:0] seg_base [TABLE_DEPTH];
  logic [63:0] seg_size [TABLE_DEPTH];
  int          seg_cnt;
  logic [63:0] brk_off;
  logic [63:0] free_sum;
  logic        mode_best;
  logic [63:0] hdr_len;
  logic [63:0] base_addr;

  fla_out_t heap_results [$];

  localparam logic [63:0] ADDR_LIMIT = 64'(SPACE_END);

  assign pending = heap_results.size();

  task automatic heap_alloc(input logic [63:0] req, output logic [63:0] addr,
                            output logic [63:0] granted, output logic [2:0] st);
    logic [63:0] need, len, gap, blk;
    int pick;
    bool_found: begin end
    need = req + hdr_len;
    pick = -1;
    addr = 0;
    granted = 0;
    for (int i = 0; i < seg_cnt; i++) begin
      if (!mode_best) begin
        if (seg_size[i] >= need) begin
          pick = i;
          break;
        end
      end else begin
        if (seg_size[i] == need) begin
          pick = i;
          break;
        end
        if (seg_size[i] > need && (pick < 0 || seg_size[i] < seg_size[pick])) pick = i;
      end
    end
    if (pick >= 0) begin
      blk = seg_base[pick];
      len = seg_size[pick];
      gap = len - need;
      if (gap <= hdr_len) begin
        for (int j = pick; j < seg_cnt - 1; j++) begin
          seg_base[j] = seg_base[j+1];
          seg_size[j] = seg_size[j+1];
        end
        seg_cnt--;
        granted = len;
      end else begin
        seg_base[pick] = blk + need;
        seg_size[pick] = gap;
        granted = need;
      end
      free_sum -= granted;
      addr = blk + hdr_len;
      st = ST_REUSED;
    end else begin
      blk = base_addr + brk_off;
      if (blk + need > ADDR_LIMIT || brk_off + need > 64'hFFFF_FFFF) begin
        st = ST_EXHAUSTED;
      end else begin
        brk_off += need;
        granted = need;
        addr = blk + hdr_len;
        st = ST_GROWN;
      end
    end
  endtask

  function automatic logic [2:0] heap_free(input logic [63:0] payload, input logic [63:0] len);
    logic [63:0] lo, hi;
    int pos;
    logic left_adj, right_adj;
    pos = 0;
    if (len == 0 || payload < hdr_len) return ST_IGNORED;
    lo = payload - hdr_len;
    hi = lo + len;
    if (hi > ADDR_LIMIT) return ST_IGNORED;
    while (pos < seg_cnt && seg_base[pos] <= lo) pos++;
    if (pos > 0 && seg_base[pos-1] + seg_size[pos-1] > lo) return ST_IGNORED;
    if (pos < seg_cnt && hi > seg_base[pos]) return ST_IGNORED;
    left_adj  = pos > 0 && seg_base[pos-1] + seg_size[pos-1] == lo;
    right_adj = pos < seg_cnt && hi == seg_base[pos];
    if (left_adj && right_adj) begin
      seg_size[pos-1] += len + seg_size[pos];
      for (int j = pos; j < seg_cnt - 1; j++) begin
        seg_base[j] = seg_base[j+1];
        seg_size[j] = seg_size[j+1];
      end
      seg_cnt--;
    end else if (left_adj) begin
      seg_size[pos-1] += len;
    end else if (right_adj) begin
      seg_base[pos] = lo;
      seg_size[pos] += len;
    end else begin
      if (seg_cnt >= TABLE_DEPTH) return ST_FULL;
      for (int j = seg_cnt; j > pos; j--) begin
        seg_base[j] = seg_base[j-1];
        seg_size[j] = seg_size[j-1];
      end
      seg_base[pos] = lo;
      seg_size[pos] = len;
      seg_cnt++;
    end
    free_sum += len;
    return ST_FREED;
  endfunction

  task automatic report(input string field, input logic [31:0] exp_v, input logic [31:0] act_v);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
    errors++;
  endtask

  always @(posedge clk) begin
    logic [63:0] addr, granted;
    logic [2:0]  st;
    fla_out_t    want;
    if (!rst_n) begin
      seg_cnt   = 0;
      brk_off   = 0;
      free_sum  = 0;
      mode_best = 1'b0;
      hdr_len   = 64'd32;
      base_addr = 64'd0;
      heap_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_FIT_MODE:  mode_best = cfg_pwdata[0];
          REG_HEADER:    hdr_len = 64'(cfg_pwdata[6:0]);
          REG_HEAP_BASE: base_addr = 64'(cfg_pwdata);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        addr = 0;
        granted = 0;
        if (in_data.opcode == OP_ALLOC) heap_alloc(64'(in_data.request_bytes), addr, granted, st);
        else st = heap_free(64'(in_data.payload_address), 64'(in_data.block_bytes));
        want.result_address = addr[31:0];
        want.granted_bytes  = granted[31:0];
        want.status         = st;
        want.segment_bytes  = brk_off[31:0];
        want.free_bytes     = free_sum[31:0];
        heap_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (heap_results.size() == 0) begin
          $display("%0t: result transfer with none expected, actual %h", $time, out_data);
          errors++;
        end else begin
          want = heap_results.pop_front();
          if (out_data.result_address !== want.result_address)
            report("result_address", want.result_address, out_data.result_address);
          if (out_data.granted_bytes !== want.granted_bytes)
            report("granted_bytes", want.granted_bytes, out_data.granted_bytes);
          if (out_data.status !== want.status)
            report("status", 32'(want.status), 32'(out_data.status));
          if (out_data.segment_bytes !== want.segment_bytes)
            report("segment_bytes", want.segment_bytes, out_data.segment_bytes);
          if (out_data.free_bytes !== want.free_bytes)
            report("free_bytes", want.free_bytes, out_data.free_bytes);
        end
      end
    end
  end

  initial errors = 0;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the free-list allocator
// Runs several register settings; each phase mixes allocations, frees of live
// blocks and malformed frees, with random idling outside the quiet phase and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  import fla_pkg::*;

  typedef struct {
    logic [31:0] blk_start;
    logic [31:0] blk_len;
  } live_blk_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  fla_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  fla_out_t    out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          errors;
  int          pending;

  int          sent_cnt;
  int          recv_cnt;
  logic [31:0] cur_hdr;
  logic        quiet;
  logic        press_req;
  logic        press_armed;
  int          press_left;
  live_blk_t   live_blocks [$];

  free_list_allocator dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  fla_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready, .cfg_paddr, .cfg_pwdata,
    .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (press_left > 0) begin
      press_left <= press_left - 1;
    end else if (press_req && !press_armed) begin
      press_left  <= 400;
      press_armed <= 1'b1;
    end
    out_stall <= (press_left > 1) || (!quiet && $urandom_range(0, 99) < 15);
  end

  // remember granted blocks so later frees are well formed
  always @(posedge clk) begin
    live_blk_t b;
    if (rst_n && out_valid && !out_stall) begin
      recv_cnt++;
      if (out_data.status == ST_REUSED || out_data.status == ST_GROWN) begin
        b.blk_start = out_data.result_address - cur_hdr;
        b.blk_len   = out_data.granted_bytes;
        live_blocks.push_back(b);
      end
    end
  end

  task automatic send_item(input fla_in_t d);
    if (!quiet && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall);
    sent_cnt++;
  endtask

  // drop valid first so the last item is not offered again once the block idles
  task automatic drain();
    in_valid <= 1'b0;
    wait (sent_cnt == recv_cnt);
    repeat (TABLE_DEPTH + 8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == REG_HEADER) cur_hdr = 32'(val[6:0]);
  endtask

  task automatic set_phase(input logic fit, input logic [31:0] hdr, input logic [31:0] base);
    cfg_write(REG_FIT_MODE, 32'(fit));
    cfg_write(REG_HEADER, hdr);
    cfg_write(REG_HEAP_BASE, base);
    @(posedge clk);
  endtask

  function automatic fla_in_t mk_alloc(input logic [31:0] req);
    fla_in_t d;
    d.opcode          = OP_ALLOC;
    d.request_bytes   = req;
    d.payload_address = $urandom;
    d.block_bytes     = $urandom;
    return d;
  endfunction

  function automatic fla_in_t mk_free(input logic [31:0] pay, input logic [31:0] len);
    fla_in_t d;
    d.opcode          = OP_FREE;
    d.request_bytes   = $urandom;
    d.payload_address = pay;
    d.block_bytes     = len;
    return d;
  endfunction

  task automatic free_live(input int idx);
    live_blk_t b;
    b = live_blocks[idx];
    live_blocks.delete(idx);
    send_item(mk_free(b.blk_start + cur_hdr, b.blk_len));
  endtask

  task automatic random_items(input int n);
    int r;
    logic [31:0] req;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 52 || (r < 90 && live_blocks.size() == 0)) begin
        r = $urandom_range(0, 99);
        if (r < 65) req = $urandom_range(0, 256);
        else if (r < 90) req = $urandom_range(0, 4096);
        else if (r < 95) req = $urandom;
        else req = $urandom_range(0, 1 << 20);
        send_item(mk_alloc(req));
      end else if (r < 90) begin
        free_live($urandom_range(0, live_blocks.size() - 1));
      end else if (r < 95) begin
        send_item(mk_free($urandom, $urandom));
      end else begin
        // free crossing a live block or partly inside the free space
        send_item(mk_free($urandom_range(0, 8192), $urandom_range(0, 512)));
      end
    end
  endtask

  // many small grants, then every other one freed, to run the table full
  task automatic fragment_heap();
    live_blk_t picks [$];
    int n0;
    n0 = live_blocks.size();
    for (int k = 0; k < 150; k++) send_item(mk_alloc(32'd8));
    drain();
    for (int k = live_blocks.size() - 1; k >= n0; k--) begin
      if (((k - n0) % 2) == 0) begin
        picks.push_front(live_blocks[k]);
        live_blocks.delete(k);
      end
    end
    foreach (picks[i]) send_item(mk_free(picks[i].blk_start + cur_hdr, picks[i].blk_len));
  endtask

  initial begin
    live_blk_t b;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    out_stall   = 1'b0;
    quiet       = 1'b0;
    press_req   = 1'b0;
    press_armed = 1'b0;
    press_left  = 0;
    sent_cnt    = 0;
    recv_cnt    = 0;
    cur_hdr     = 32'd32;
    rst_n       = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults, written explicitly
    set_phase(1'b0, 32'd32, 32'h0);
    send_item(mk_alloc(32'd100));
    send_item(mk_alloc(32'd0));
    send_item(mk_alloc(32'd200));
    send_item(mk_alloc(32'd300));
    send_item(mk_alloc(32'hFFFF_FFFF));
    send_item(mk_alloc(32'h8000_0000));
    drain();
    b = live_blocks[0];
    free_live(0);
    send_item(mk_free(b.blk_start + cur_hdr, b.blk_len));       // overlaps: ignored
    send_item(mk_free(32'h1000_0000, 32'd0));                    // zero length
    send_item(mk_free(32'd0, 32'd64));                           // below header
    send_item(mk_free(32'hFFFF_FFF0, 32'h100));                  // past the top
    send_item(mk_free(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(mk_alloc(32'd40));                                 // split of the freed block
    send_item(mk_alloc(32'd28));                                 // leftover within a header
    drain();
    free_live(1);                                                // neighbors coalesce
    free_live(0);
    free_live(0);
    send_item(mk_alloc(32'd0));
    send_item(mk_alloc(32'd500));
    fragment_heap();
    random_items(150);
    drain();

    // best fit, smallest header, no idling anywhere
    quiet = 1'b1;
    set_phase(1'b1, 32'd8, 32'h0000_1000);
    random_items(300);
    drain();
    quiet = 1'b0;

    // largest header, heap near the top of the space, long output hold-off
    set_phase(1'b1, 32'd64, 32'hFFFF_0000);
    press_req = 1'b1;
    random_items(250);
    drain();

    set_phase(1'b0, 32'd8, 32'hFFFF_FFFF);
    random_items(100);
    drain();

    set_phase(1'b1, 32'd64, 32'h0);
    random_items(300);
    drain();

    repeat (TABLE_DEPTH + 20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
